// ===== hw/rtl/rps_pkg.sv =====
// Shared types and codes for the rectangle pair splitter.
// Has no dependencies; rectangle_pair_split uses it by scoped names.
`default_nettype none

package rps_pkg;

  localparam int unsigned COORD_W = 16;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t left;
    coord_t top;
    coord_t right;
    coord_t bottom;
  } rect_t;

  // Outcome of one pair, carried on every result of that pair.
  typedef enum logic [1:0] {
    OUT_NOTHING = 2'd0,
    OUT_REMOVE  = 2'd1,
    OUT_INSERT  = 2'd2
  } outcome_t;

  // Which rectangle a result carries; also the emit sequence index.
  typedef enum logic [1:0] {
    WHICH_FIRST  = 2'd0,
    WHICH_SECOND = 2'd1,
    WHICH_NEW    = 2'd2
  } which_t;

  // Corner containment tests and edge comparisons of one pair.
  typedef struct packed {
    logic a_has_b_tl;     // first holds second's top-left corner
    logic a_has_b_bl;     // first holds second's bottom-left corner
    logic b_has_a_tr;     // second holds first's top-right corner
    logic b_has_a_far;    // second holds first's far corner
    logic a_has_b_far;    // first holds second's far corner
    logic b_crosses_a;    // second crosses first vertically
    logic eq_left;
    logic eq_top;
    logic eq_right;
    logic eq_bottom;
    logic a_bot_lt_b;
    logic a_right_lt_b;
  } flags_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rectangle_pair_split.sv =====
// Rectangle pair splitter: compare, decide and emit pipeline.
// Depends on rps_pkg for rectangle, flag and code types.
`default_nettype none

// Usage:
// A pair of rectangles is transferred on the in_ ports at a rising edge where
// start is high and busy is low. Each pair yields one to three results on the
// out_ ports, one per cycle, each marked by a one-cycle out_valid strobe:
// the first rectangle, then the second (unless it is removed), then the new
// piece (only on an insert). out_last_of_run marks the final result of a pair.
// Pipeline: a pair moves through the input register, the compare stage, the
// decision stage and the emitter, whose registers drive the out_ ports.
// Throughput: the emitter puts out one result per cycle, one to three for each
// pair; pairs can be transferred back to back, and busy rises while every
// stage ahead of the emitter is full and it has results left.
// The receiver cannot stall; results are never held back by the output side.
// Reset (rst_n low, synchronous) empties all stages; busy is low afterward.
// There are no configuration registers.
module rectangle_pair_split (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  output logic                  busy,
  input  wire  rps_pkg::coord_t in_first_left,
  input  wire  rps_pkg::coord_t in_first_top,
  input  wire  rps_pkg::coord_t in_first_right,
  input  wire  rps_pkg::coord_t in_first_bottom,
  input  wire  rps_pkg::coord_t in_second_left,
  input  wire  rps_pkg::coord_t in_second_top,
  input  wire  rps_pkg::coord_t in_second_right,
  input  wire  rps_pkg::coord_t in_second_bottom,
  output logic                  out_valid,
  output logic [1:0]            out_which_rect,
  output rps_pkg::coord_t       out_left,
  output rps_pkg::coord_t       out_top,
  output rps_pkg::coord_t       out_right,
  output rps_pkg::coord_t       out_bottom,
  output logic [1:0]            out_outcome,
  output logic                  out_last_of_run
);

  // Stage valid bits and payloads.
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  rps_pkg::rect_t s1_a_r, s1_b_r, s2_a_r, s2_b_r;
  rps_pkg::flags_t s2_f_r;
  rps_pkg::rect_t s3_a_r, s3_b_r, s3_n_r;
  rps_pkg::outcome_t s3_oc_r;
  rps_pkg::rect_t s4_a_r, s4_b_r, s4_n_r;
  rps_pkg::outcome_t s4_oc_r;
  rps_pkg::which_t s4_idx_r, s4_idx_nxt;

  logic acc1, acc2, acc3, acc4;
  logic s4_last;
  logic in_xfer;

  // A stage takes new data when it is empty or its content moves on.
  always_comb begin
    acc4 = !s4_v_r || s4_last;
    acc3 = !s3_v_r || acc4;
    acc2 = !s2_v_r || acc3;
    acc1 = !s1_v_r || acc2;
  end

  assign busy    = !acc1;
  assign in_xfer = start && acc1;

  // Stage 1: input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (acc1) begin
      s1_v_r <= start;
    end
    if (in_xfer) begin
      s1_a_r <= '{in_first_left, in_first_top, in_first_right, in_first_bottom};
      s1_b_r <= '{in_second_left, in_second_top, in_second_right, in_second_bottom};
    end
  end

  // Stage 2: corner containment and edge comparisons. Far corners sit at
  // right-1 and bottom-1, so x-1 >= l becomes x > l and x-1 < r becomes x <= r.
  rps_pkg::flags_t f_nxt;
  always_comb begin
    rps_pkg::rect_t a;
    rps_pkg::rect_t b;
    a = s1_a_r;
    b = s1_b_r;
    f_nxt.a_has_b_tl  = (a.left <= b.left) && (b.left < a.right) &&
                        (a.top <= b.top) && (b.top < a.bottom);
    f_nxt.a_has_b_bl  = (a.left <= b.left) && (b.left < a.right) &&
                        (a.top < b.bottom) && (b.bottom <= a.bottom);
    f_nxt.b_has_a_tr  = (b.left < a.right) && (a.right <= b.right) &&
                        (b.top <= a.top) && (a.top < b.bottom);
    f_nxt.b_has_a_far = (b.left < a.right) && (a.right <= b.right) &&
                        (b.top < a.bottom) && (a.bottom <= b.bottom);
    f_nxt.a_has_b_far = (a.left < b.right) && (b.right <= a.right) &&
                        (a.top < b.bottom) && (b.bottom <= a.bottom);
    f_nxt.b_crosses_a = (b.left < a.right) && (b.top < a.top) && (b.bottom > a.bottom);
    f_nxt.eq_left      = (b.left == a.left);
    f_nxt.eq_top       = (b.top == a.top);
    f_nxt.eq_right     = (b.right == a.right);
    f_nxt.eq_bottom    = (b.bottom == a.bottom);
    f_nxt.a_bot_lt_b   = (a.bottom < b.bottom);
    f_nxt.a_right_lt_b = (a.right < b.right);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (acc2) begin
      s2_v_r <= s1_v_r;
    end
    if (acc2) begin
      s2_a_r <= s1_a_r;
      s2_b_r <= s1_b_r;
      s2_f_r <= f_nxt;
    end
  end

  // Stage 3: walk the decision tree and rewrite the rectangles.
  rps_pkg::rect_t a_nxt, b_nxt, n_nxt;
  rps_pkg::outcome_t oc_nxt;
  always_comb begin
    rps_pkg::rect_t a;
    rps_pkg::rect_t b;
    rps_pkg::flags_t f;
    a = s2_a_r;
    b = s2_b_r;
    f = s2_f_r;
    a_nxt  = a;
    b_nxt  = b;
    n_nxt  = '0;
    oc_nxt = rps_pkg::OUT_NOTHING;
    if (!f.a_has_b_tl) begin
      if (!f.a_has_b_bl) begin
        if (!f.b_has_a_tr) begin
          if (f.b_crosses_a) begin
            n_nxt        = '{b.left, a.bottom, b.right, b.bottom};
            b_nxt.bottom = a.top;
            oc_nxt       = rps_pkg::OUT_INSERT;
          end
        end else begin
          a_nxt.right = b.left;
        end
      end else if (!f.a_has_b_far) begin
        n_nxt        = '{a.right, a.top, b.right, b.bottom};
        b_nxt.bottom = a.top;
        oc_nxt       = rps_pkg::OUT_INSERT;
      end else begin
        b_nxt.bottom = a.top;
      end
    end else if (f.b_has_a_far) begin
      if (f.eq_left) begin
        if (f.eq_top) begin
          if (f.a_bot_lt_b) begin
            b_nxt.top = a.bottom;
            if (f.a_right_lt_b) begin
              n_nxt  = '{a.right, a.top, b.right, a.bottom};
              oc_nxt = rps_pkg::OUT_INSERT;
            end
          end else if (f.a_right_lt_b) begin
            b_nxt.left = a.right;
          end else begin
            oc_nxt = rps_pkg::OUT_REMOVE;
          end
        end else begin
          a_nxt.bottom = b.top;
        end
      end else if (f.eq_top) begin
        // Equal tops with differing lefts: the first is cut back to the second.
        a_nxt.right = b.left;
      end else begin
        n_nxt        = '{a.left, b.top, b.left, a.bottom};
        a_nxt.bottom = b.top;
        oc_nxt       = rps_pkg::OUT_INSERT;
      end
    end else if (f.a_has_b_far) begin
      oc_nxt = rps_pkg::OUT_REMOVE;
    end else if (f.a_has_b_bl) begin
      if (f.eq_right) begin
        oc_nxt = rps_pkg::OUT_REMOVE;
      end else begin
        b_nxt.left = a.right;
      end
    end else if (f.eq_bottom) begin
      oc_nxt = rps_pkg::OUT_REMOVE;
    end else begin
      b_nxt.top = a.bottom;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (acc3) begin
      s3_v_r <= s2_v_r;
    end
    if (acc3) begin
      s3_a_r  <= a_nxt;
      s3_b_r  <= b_nxt;
      s3_n_r  <= n_nxt;
      s3_oc_r <= oc_nxt;
    end
  end

  // Stage 4: emitter, one result per cycle in first, second, new order.
  always_comb begin
    case (s4_idx_r)
      rps_pkg::WHICH_FIRST:  s4_last = (s4_oc_r == rps_pkg::OUT_REMOVE);
      rps_pkg::WHICH_SECOND: s4_last = (s4_oc_r != rps_pkg::OUT_INSERT);
      default:               s4_last = 1'b1;
    endcase
  end

  always_comb begin
    case (s4_idx_r)
      rps_pkg::WHICH_FIRST: s4_idx_nxt = rps_pkg::WHICH_SECOND;
      default:              s4_idx_nxt = rps_pkg::WHICH_NEW;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r   <= 1'b0;
      s4_idx_r <= rps_pkg::WHICH_FIRST;
    end else if (acc4) begin
      s4_v_r   <= s3_v_r;
      s4_idx_r <= rps_pkg::WHICH_FIRST;
    end else begin
      s4_idx_r <= s4_idx_nxt;
    end
    if (acc4) begin
      s4_a_r  <= s3_a_r;
      s4_b_r  <= s3_b_r;
      s4_n_r  <= s3_n_r;
      s4_oc_r <= s3_oc_r;
    end
  end

  rps_pkg::rect_t out_rect;
  always_comb begin
    case (s4_idx_r)
      rps_pkg::WHICH_FIRST:  out_rect = s4_a_r;
      rps_pkg::WHICH_SECOND: out_rect = s4_b_r;
      default:               out_rect = s4_n_r;
    endcase
  end

  assign out_valid       = s4_v_r;
  assign out_which_rect  = s4_idx_r;
  assign out_left        = out_rect.left;
  assign out_top         = out_rect.top;
  assign out_right       = out_rect.right;
  assign out_bottom      = out_rect.bottom;
  assign out_outcome     = s4_oc_r;
  assign out_last_of_run = s4_last;

`ifndef ASSERT_OFF
  a_remove_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_outcome == rps_pkg::OUT_REMOVE) |->
      out_last_of_run && (out_which_rect == rps_pkg::WHICH_FIRST))
    else $error("removed pair emitted more than the first rectangle");

  a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |=>
      out_valid && (out_which_rect == $past(out_which_rect) + 2'd1) &&
      (out_outcome == $past(out_outcome)))
    else $error("results of one pair are not consecutive");

  a_new_piece: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_which_rect == rps_pkg::WHICH_NEW) |->
      (out_outcome == rps_pkg::OUT_INSERT) && out_last_of_run)
    else $error("new piece emitted without an insert");

  a_decide_held: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r && !acc3 |=> s3_v_r && $stable(s3_a_r) && $stable(s3_oc_r))
    else $error("decision stage lost data while stalled");
`endif

endmodule

`default_nettype wire

// ===== test/rectangle_pair_split_test.sv =====
// Self-checking testbench for rectangle_pair_split: directed overlap cases, extreme
// coordinates and random pairs under varied input gaps, checked against a local predictor.
// Depends on rps_pkg for the coordinate, rectangle, outcome and which-rectangle types.
`default_nettype none

module rectangle_pair_split_test;

  localparam int CYCLE_LIMIT = 200000;

  // Working copy of a rectangle at full integer width, so far corners never wrap.
  typedef struct {
    int l;
    int t;
    int r;
    int b;
  } box_t;

  typedef struct {
    box_t              a;
    box_t              b;
    box_t              n;
    rps_pkg::outcome_t oc;
  } split_t;

  typedef struct {
    rps_pkg::which_t   which;
    rps_pkg::rect_t    box;
    rps_pkg::outcome_t oc;
    logic              last;
  } piece_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  rps_pkg::coord_t in_first_left = '0;
  rps_pkg::coord_t in_first_top = '0;
  rps_pkg::coord_t in_first_right = '0;
  rps_pkg::coord_t in_first_bottom = '0;
  rps_pkg::coord_t in_second_left = '0;
  rps_pkg::coord_t in_second_top = '0;
  rps_pkg::coord_t in_second_right = '0;
  rps_pkg::coord_t in_second_bottom = '0;
  logic            out_valid;
  logic [1:0]      out_which_rect;
  rps_pkg::coord_t out_left;
  rps_pkg::coord_t out_top;
  rps_pkg::coord_t out_right;
  rps_pkg::coord_t out_bottom;
  logic [1:0]      out_outcome;
  logic            out_last_of_run;

  piece_t  pending_pieces[$];
  int      fail_count = 0;
  int      cycle_count = 0;
  int      sender_idle_pct = 0;

  rectangle_pair_split dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_first_left   (in_first_left),
    .in_first_top    (in_first_top),
    .in_first_right  (in_first_right),
    .in_first_bottom (in_first_bottom),
    .in_second_left  (in_second_left),
    .in_second_top   (in_second_top),
    .in_second_right (in_second_right),
    .in_second_bottom(in_second_bottom),
    .out_valid       (out_valid),
    .out_which_rect  (out_which_rect),
    .out_left        (out_left),
    .out_top         (out_top),
    .out_right       (out_right),
    .out_bottom      (out_bottom),
    .out_outcome     (out_outcome),
    .out_last_of_run (out_last_of_run)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL rectangle_pair_split");
      $finish;
    end
  end

  function automatic rps_pkg::rect_t make_rect(int l, int t, int r, int b);
    rps_pkg::rect_t x;
    x.left = l[15:0];
    x.top = t[15:0];
    x.right = r[15:0];
    x.bottom = b[15:0];
    return x;
  endfunction

  function automatic box_t to_box(rps_pkg::rect_t x);
    box_t w;
    w.l = int'(x.left);
    w.t = int'(x.top);
    w.r = int'(x.right);
    w.b = int'(x.bottom);
    return w;
  endfunction

  function automatic rps_pkg::rect_t to_rect(box_t w);
    return make_rect(w.l, w.t, w.r, w.b);
  endfunction

  // Half-open containment: left and top inclusive, right and bottom exclusive.
  function automatic bit covers(box_t w, int x, int y);
    return w.l <= x && x < w.r && w.t <= y && y < w.b;
  endfunction

  function automatic split_t split_rectangles(box_t a, box_t b);
    split_t s;
    int     a_fx;
    int     a_fy;
    int     b_fx;
    int     b_fy;
    a_fx = a.r - 1;
    a_fy = a.b - 1;
    b_fx = b.r - 1;
    b_fy = b.b - 1;
    s.a = a;
    s.b = b;
    s.n = '{0, 0, 0, 0};
    s.oc = rps_pkg::OUT_NOTHING;
    if (!covers(a, b.l, b.t)) begin
      if (!covers(a, b.l, b_fy)) begin
        if (!covers(b, a_fx, a.t)) begin
          // The second rectangle runs through the first from above to below.
          if (b.l < a.r && b.t < a.t && b.b > a.b) begin
            s.n = '{b.l, a.b, b.r, b.b};
            s.b.b = a.t;
            s.oc = rps_pkg::OUT_INSERT;
          end
        end else begin
          s.a.r = b.l;
        end
      end else if (!covers(a, b_fx, b_fy)) begin
        s.n = '{a.r, a.t, b.r, b.b};
        s.b.b = a.t;
        s.oc = rps_pkg::OUT_INSERT;
      end else begin
        s.b.b = a.t;
      end
    end else if (covers(b, a_fx, a_fy)) begin
      if (b.l == a.l) begin
        if (b.t == a.t) begin
          if (a.b < b.b) begin
            s.b.t = a.b;
            if (a.r < b.r) begin
              s.n = '{a.r, a.t, b.r, a.b};
              s.oc = rps_pkg::OUT_INSERT;
            end
          end else if (a.r < b.r) begin
            s.b.l = a.r;
          end else begin
            s.oc = rps_pkg::OUT_REMOVE;
          end
        end else begin
          s.a.b = b.t;
        end
      end else if (a.t == b.t) begin
        s.a.r = b.l;
      end else begin
        s.n = '{a.l, b.t, b.l, a.b};
        s.a.b = b.t;
        s.oc = rps_pkg::OUT_INSERT;
      end
    end else if (covers(a, b_fx, b_fy)) begin
      s.oc = rps_pkg::OUT_REMOVE;
    end else if (covers(a, b.l, b_fy)) begin
      if (b.r == a.r) s.oc = rps_pkg::OUT_REMOVE;
      else s.b.l = a.r;
    end else if (b.b == a.b) begin
      s.oc = rps_pkg::OUT_REMOVE;
    end else begin
      s.b.t = a.b;
    end
    return s;
  endfunction

  // Appends one expected result at the tail of the pending list.
  function automatic void queue_piece(piece_t p);
    pending_pieces = {pending_pieces, p};
  endfunction

  function automatic void queue_pieces(rps_pkg::rect_t first, rps_pkg::rect_t second);
    split_t s;
    piece_t p;
    s = split_rectangles(to_box(first), to_box(second));
    p.oc = s.oc;
    p.which = rps_pkg::WHICH_FIRST;
    p.box = to_rect(s.a);
    p.last = (s.oc == rps_pkg::OUT_REMOVE);
    queue_piece(p);
    if (s.oc != rps_pkg::OUT_REMOVE) begin
      p.which = rps_pkg::WHICH_SECOND;
      p.box = to_rect(s.b);
      p.last = (s.oc == rps_pkg::OUT_NOTHING);
      queue_piece(p);
    end
    if (s.oc == rps_pkg::OUT_INSERT) begin
      p.which = rps_pkg::WHICH_NEW;
      p.box = to_rect(s.n);
      p.last = 1'b1;
      queue_piece(p);
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_pair(input rps_pkg::rect_t first, input rps_pkg::rect_t second);
    while ($urandom_range(99) < sender_idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    in_first_left = first.left;
    in_first_top = first.top;
    in_first_right = first.right;
    in_first_bottom = first.bottom;
    in_second_left = second.left;
    in_second_top = second.top;
    in_second_right = second.right;
    in_second_bottom = second.bottom;
    do @(posedge clk); while (busy);
    queue_pieces(first, second);
    @(negedge clk);
  endtask

  always @(posedge clk) begin : check_results
    piece_t want;
    if (rst_n && out_valid) begin
      if (pending_pieces.size() == 0) begin
        $error("unexpected result: which_rect %0d left %0d top %0d", out_which_rect,
               out_left, out_top);
        fail_count++;
      end else begin
        want = pending_pieces.pop_front();
        if (out_which_rect !== want.which) begin
          $error("which_rect: expected %0d, actual %0d", want.which, out_which_rect);
          fail_count++;
        end
        if (out_left !== want.box.left) begin
          $error("out_left: expected %0d, actual %0d", want.box.left, out_left);
          fail_count++;
        end
        if (out_top !== want.box.top) begin
          $error("out_top: expected %0d, actual %0d", want.box.top, out_top);
          fail_count++;
        end
        if (out_right !== want.box.right) begin
          $error("out_right: expected %0d, actual %0d", want.box.right, out_right);
          fail_count++;
        end
        if (out_bottom !== want.box.bottom) begin
          $error("out_bottom: expected %0d, actual %0d", want.box.bottom, out_bottom);
          fail_count++;
        end
        if (out_outcome !== want.oc) begin
          $error("outcome: expected %0d, actual %0d", want.oc, out_outcome);
          fail_count++;
        end
        if (out_last_of_run !== want.last) begin
          $error("last_of_run: expected %0d, actual %0d", want.last, out_last_of_run);
          fail_count++;
        end
      end
    end
  end

  // Directed pairs covering many of the ways the two rectangles can be trimmed or split.
  task automatic test_overlap_cases();
    sender_idle_pct = 0;
    send_pair(make_rect(0, 10, 20, 20), make_rect(5, 0, 15, 30));
    send_pair(make_rect(0, 0, 10, 10), make_rect(20, 20, 30, 30));
    send_pair(make_rect(0, 0, 10, 10), make_rect(5, -5, 20, 20));
    send_pair(make_rect(0, 10, 10, 20), make_rect(5, 0, 20, 15));
    send_pair(make_rect(0, 10, 20, 20), make_rect(5, 0, 15, 15));
    send_pair(make_rect(0, 0, 10, 10), make_rect(0, 0, 20, 20));
    send_pair(make_rect(0, 0, 20, 10), make_rect(0, 0, 20, 20));
    send_pair(make_rect(0, 0, 10, 20), make_rect(0, 0, 20, 20));
    send_pair(make_rect(0, 0, 10, 10), make_rect(0, 0, 10, 10));
    send_pair(make_rect(0, 0, 10, 10), make_rect(0, 5, 10, 20));
    // Equal tops with different lefts: the first is cut back to the second's left.
    send_pair(make_rect(0, 0, 10, 10), make_rect(5, 0, 20, 20));
    send_pair(make_rect(0, 0, 10, 10), make_rect(5, 5, 20, 20));
    send_pair(make_rect(0, 0, 20, 20), make_rect(5, 5, 10, 10));
    send_pair(make_rect(0, 0, 10, 20), make_rect(5, 5, 30, 15));
    // An inverted second rectangle still takes the ordinary decisions.
    send_pair(make_rect(0, 0, 10, 10), make_rect(5, 5, 20, -5));
    // Pair out of corner order, and an empty first rectangle.
    send_pair(make_rect(5, 5, 20, 20), make_rect(0, 0, 10, 10));
    send_pair(make_rect(3, 3, 3, 3), make_rect(0, 0, 10, 10));
  endtask

  task automatic test_edge_extremes();
    sender_idle_pct = 0;
    send_pair(make_rect(-32768, -32768, 32767, 32767), make_rect(-32768, -32768, 32767, 32767));
    send_pair(make_rect(-32768, -32768, 32767, 32767), make_rect(0, 0, -32768, -32768));
    send_pair(make_rect(32767, 32767, -32768, -32768), make_rect(-32768, -32768, 32767, 32767));
    send_pair(make_rect(-32768, 0, 0, 32767), make_rect(-1, -32768, 32767, -1));
    send_pair(make_rect(-32768, -32768, 0, 0), make_rect(-1, -1, 32767, 32767));
    send_pair(make_rect(-32768, -100, 32767, 100), make_rect(0, -32768, 10, 32767));
  endtask

  // Mostly overlapping pairs near a random point, with shared edges now and then;
  // the rest are raw random coordinates.
  task automatic test_random_traffic(input int count, input int idle_pct);
    rps_pkg::rect_t first;
    rps_pkg::rect_t second;
    int             bx;
    int             by;
    int             x;
    int             y;
    sender_idle_pct = idle_pct;
    repeat (count) begin
      if ($urandom_range(4) == 0) begin
        first = rps_pkg::rect_t'({$urandom, $urandom});
        second = rps_pkg::rect_t'({$urandom, $urandom});
      end else begin
        bx = int'($urandom_range(65535 - 30)) - 32768;
        by = int'($urandom_range(65535 - 30)) - 32768;
        x = bx + $urandom_range(8);
        y = by + $urandom_range(8);
        first = make_rect(x, y, x + $urandom_range(1, 12), y + $urandom_range(1, 12));
        x = bx + $urandom_range(10);
        y = by + $urandom_range(10);
        second = make_rect(x, y, x + $urandom_range(1, 12), y + $urandom_range(1, 12));
        if ($urandom_range(3) == 0) second.left = first.left;
        if ($urandom_range(3) == 0) second.top = first.top;
        if ($urandom_range(3) == 0) second.right = first.right;
        if ($urandom_range(3) == 0) second.bottom = first.bottom;
      end
      send_pair(first, second);
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    test_overlap_cases();
    test_edge_extremes();
    test_random_traffic(35, 0);
    test_random_traffic(35, 62);
    test_random_traffic(30, 0);
    test_random_traffic(30, 29);
    start = 1'b0;
    while (pending_pieces.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS rectangle_pair_split");
    end else begin
      $display("FAIL rectangle_pair_split");
    end
    $finish;
  end

endmodule

`default_nettype wire
